// File: rtl/core/ffra_pkg.sv
package ffra_pkg;

    localparam int MAX_RANGES = 64;
    // page size must be a power of two
    localparam int PAGE_BYTES = 4096;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int ADDR_W     = 64;
    localparam int REQ_W      = 48;
    localparam int SIZE_W     = REQ_W + 1;
    localparam int STAT_W     = 2;

    localparam logic [SIZE_W-1:0] PAGE_MASK = SIZE_W'(PAGE_BYTES - 1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFIT    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    localparam logic CFG_HEAP_START = 1'b0;
    localparam logic CFG_HEAP_END   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FIT,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              calc_end;
        logic              calc_fit;
        logic              scan;
        logic              ins;
        logic              del;
        logic              is_alloc;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] heap_end;
        logic [CNT_W-1:0]  count;
    } ffra_cmd_t;

    // data one cell shows its neighbors
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] endv;
    } ffra_link_t;

    // reductions over the chain, back to the controller
    typedef struct packed {
        logic              any_hit;
        logic              any_live;
        logic [ADDR_W-1:0] base0;
        logic [ADDR_W-1:0] hit_end;
    } ffra_stat_t;

endpackage

// File: rtl/core/first_fit_range_allocator_unit.sv
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tuser op, s_tdata req_size, req_addr
// m_      | out | m_tvalid/m_tready  | m_tdata status, grant_addr
// cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// One word in flight. An alloc steps through PREP, FIT, SCAN, SHIFT and DONE;
// a free skips PREP. A miss leaves SCAN for DONE without SHIFT, and an alloc
// skips SCAN when the gap in front of the first range fits. Zero-size or full
// allocs and zero-address frees go straight to DONE.
// s_tready returns in the cycle after the result is loaded.
// Reset clears the count, bounds and handshake state; table cell base, length and end hold no reset.
// A new word is taken while a result still waits in the output register.
module first_fit_range_allocator_unit import ffra_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [111:0]  s_tdata,  // req_size[47:0], req_addr[111:48]
    input  logic          s_tuser,  // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [71:0]   m_tdata,  // status[1:0], grant_addr[65:2], zero pad
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [63:0]   cfg_wdata
);

    ffra_cmd_t         cmd;
    ffra_stat_t        stat;
    ffra_link_t        links [MAX_RANGES];
    logic [MAX_RANGES-1:0] passed_v, tok_v, live_v, hit_v;
    logic [ADDR_W-1:0] heap_start;
    logic [STAT_W-1:0] m_status;
    logic [ADDR_W-1:0] m_grant;

    ffra_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_op       (s_tuser),
        .s_req_size (s_tdata[REQ_W-1:0]),
        .s_req_addr (s_tdata[REQ_W+ADDR_W-1:REQ_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_status   (m_status),
        .m_grant    (m_grant),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .stat       (stat),
        .cmd        (cmd),
        .heap_start (heap_start)
    );

    for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
        ffra_link_t pl, nl;
        logic       pp, pt, ph;
        if (i == 0) begin : g_head
            assign pl = '{base: '0, len: '0, endv: heap_start};
            assign pp = 1'b1;
            assign pt = 1'b0;
            assign ph = 1'b0;
        end else begin : g_body
            assign pl = links[i-1];
            assign pp = passed_v[i-1];
            assign pt = tok_v[i-1];
            assign ph = hit_v[i-1];
        end
        if (i == MAX_RANGES - 1) begin : g_tail
            assign nl = '0;
        end else begin : g_mid
            assign nl = links[i+1];
        end
        ffra_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cell_idx    (IDX_W'(i)),
            .cmd         (cmd),
            .prev_link   (pl),
            .prev_passed (pp),
            .prev_tok    (pt),
            .prev_hit    (ph),
            .next_link   (nl),
            .link        (links[i]),
            .passed      (passed_v[i]),
            .tok         (tok_v[i]),
            .tok_live    (live_v[i]),
            .hit         (hit_v[i])
        );
    end

    always_comb begin
        stat.any_hit  = |hit_v;
        stat.any_live = |live_v;
        stat.base0    = links[0].base;
        stat.hit_end  = '0;
        for (int i = 0; i < MAX_RANGES; i++) begin
            stat.hit_end = stat.hit_end | (links[i].endv & {ADDR_W{hit_v[i]}});
        end
    end

    assign m_tdata = {6'b0, m_grant, m_status};

    a_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_v))
        else $error("more than one cell hit");
    a_one_tok: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_v))
        else $error("more than one scan token");
    a_hit_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan && stat.any_hit |=> !cmd.scan)
        else $error("scan kept running after a hit");

endmodule

// File: rtl/core/ffra_cell.sv
module ffra_cell import ffra_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  ffra_cmd_t  cmd,
    input  ffra_link_t prev_link,
    input  logic       prev_passed,
    input  logic       prev_tok,
    input  logic       prev_hit,
    input  ffra_link_t next_link,
    output ffra_link_t link,
    output logic       passed,
    output logic       tok,
    output logic       tok_live,
    output logic       hit
);

    logic [ADDR_W-1:0] base_reg, len_reg, end_reg;
    logic              fit_reg;
    logic              tok_reg, passed_reg;

    logic              valid, last;
    logic [ADDR_W:0]   sum;
    logic [ADDR_W-1:0] end_sat, upper, gap;
    logic              fit_c, match;

    assign valid = {1'b0, cell_idx} < cmd.count;
    assign last  = ({1'b0, cell_idx} + CNT_W'(1)) == cmd.count;
    assign sum   = {1'b0, base_reg} + {1'b0, len_reg};
    assign end_sat = sum[ADDR_W] ? {ADDR_W{1'b1}} : sum[ADDR_W-1:0];
    assign upper = last ? cmd.heap_end : next_link.base;
    assign gap   = (upper > end_reg) ? (upper - end_reg) : '0;
    assign fit_c = gap >= ADDR_W'(cmd.size);
    assign match = base_reg == cmd.addr;

    assign tok_live = tok_reg & valid;
    assign hit      = tok_live & (cmd.is_alloc ? fit_reg : match);

    assign link   = '{base: base_reg, len: len_reg, endv: end_reg};
    assign passed = passed_reg;
    assign tok    = tok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg    <= 1'b0;
            passed_reg <= 1'b0;
        end else if (cmd.calc_fit) begin
            tok_reg    <= cell_idx == '0;
            passed_reg <= 1'b0;
        end else if (cmd.scan) begin
            tok_reg    <= prev_tok & ~prev_hit;
            passed_reg <= passed_reg | (tok_reg & (cmd.is_alloc | ~hit));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_end) begin
            end_reg <= end_sat;
        end
        if (cmd.calc_fit) begin
            fit_reg <= fit_c;
        end
        if (cmd.ins && !passed_reg) begin
            // first cell past the gap takes the new range
            if (prev_passed) begin
                base_reg <= prev_link.endv;
                len_reg  <= ADDR_W'(cmd.size);
            end else begin
                base_reg <= prev_link.base;
                len_reg  <= prev_link.len;
            end
        end else if (cmd.del && !passed_reg) begin
            base_reg <= next_link.base;
            len_reg  <= next_link.len;
        end
    end

endmodule

// File: rtl/core/ffra_ctrl.sv
module ffra_ctrl import ffra_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_op,
    input  logic [REQ_W-1:0]  s_req_size,
    input  logic [ADDR_W-1:0] s_req_addr,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [STAT_W-1:0] m_status,
    output logic [ADDR_W-1:0] m_grant,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [ADDR_W-1:0] cfg_wdata,
    input  ffra_stat_t        stat,
    output ffra_cmd_t         cmd,
    output logic [ADDR_W-1:0] heap_start
);

    state_t            state_reg, state_next;
    logic              op_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg, hs_reg, he_reg, grant_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [STAT_W-1:0] status_reg;
    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [ADDR_W-1:0] m_grant_reg;

    logic              accept, out_free, early_done, pre_fit;
    logic [SIZE_W-1:0] size_round;
    logic [ADDR_W-1:0] pre_upper;
    logic [STAT_W-1:0] early_status;

    assign accept   = s_tvalid & s_tready;
    assign out_free = ~m_valid_reg | m_tready;
    assign size_round = ({1'b0, s_req_size} + PAGE_MASK) & ~PAGE_MASK;

    always_comb begin
        early_done   = 1'b0;
        early_status = STAT_OK;
        if (s_op == OP_FREE) begin
            early_done = s_req_addr == '0;
        end else if (s_req_size == '0) begin
            early_done   = 1'b1;
            early_status = STAT_NOFIT;
        end else if (count_reg >= CNT_W'(MAX_RANGES)) begin
            early_done   = 1'b1;
            early_status = STAT_FULL;
        end
    end

    // gap in front of the first range, or the whole heap when empty
    assign pre_upper = (count_reg == '0) ? he_reg : stat.base0;
    assign pre_fit   = (pre_upper > hs_reg) &&
                       ((pre_upper - hs_reg) >= ADDR_W'(size_reg));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (early_done) state_next = S_DONE;
                    else if (s_op == OP_FREE) state_next = S_FIT;
                    else state_next = S_PREP;
                end
            end
            S_PREP:  state_next = S_FIT;
            S_FIT: begin
                if (op_reg == OP_ALLOC && pre_fit) state_next = S_SHIFT;
                else state_next = S_SCAN;
            end
            S_SCAN: begin
                if (stat.any_hit) state_next = S_SHIFT;
                else if (!stat.any_live) state_next = S_DONE;
            end
            S_SHIFT: state_next = S_DONE;
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.is_alloc = op_reg == OP_ALLOC;
        cmd.size     = size_reg;
        cmd.addr     = addr_reg;
        cmd.heap_end = he_reg;
        cmd.count    = count_reg;
        case (state_reg)
            S_IDLE:  s_tready = 1'b1;
            S_PREP:  cmd.calc_end = 1'b1;
            S_FIT:   cmd.calc_fit = 1'b1;
            S_SCAN:  cmd.scan = 1'b1;
            S_SHIFT: begin
                cmd.ins = op_reg == OP_ALLOC;
                cmd.del = op_reg == OP_FREE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            hs_reg      <= '0;
            he_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == CFG_HEAP_START) hs_reg <= cfg_wdata;
                else he_reg <= cfg_wdata;
            end
            if (state_reg == S_SHIFT) begin
                if (op_reg == OP_ALLOC) count_reg <= count_reg + CNT_W'(1);
                else count_reg <= count_reg - CNT_W'(1);
            end
            if (state_reg == S_DONE && out_free) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_op;
            size_reg   <= size_round;
            addr_reg   <= s_req_addr;
            status_reg <= early_status;
            grant_reg  <= '0;
        end
        if (state_reg == S_FIT && op_reg == OP_ALLOC && pre_fit) begin
            grant_reg <= hs_reg;
        end
        if (state_reg == S_SCAN) begin
            if (stat.any_hit) begin
                grant_reg  <= (op_reg == OP_ALLOC) ? stat.hit_end : '0;
                status_reg <= STAT_OK;
            end else if (!stat.any_live) begin
                status_reg <= (op_reg == OP_ALLOC) ? STAT_NOFIT : STAT_NOTFOUND;
            end
        end
        if (state_reg == S_DONE && out_free) begin
            m_status_reg <= status_reg;
            m_grant_reg  <= grant_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_grant    = m_grant_reg;
    assign heap_start = hs_reg;

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_RANGES))
        else $error("range count above table size");
    a_shift_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && op_reg == OP_ALLOC) |-> count_reg < CNT_W'(MAX_RANGES))
        else $error("insert into full table");
    a_del_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && op_reg == OP_FREE) |-> count_reg != '0)
        else $error("delete from empty table");

endmodule

// File: bench/first_fit_range_allocator_unit_test.sv
`timescale 1ns / 1ps
module first_fit_range_allocator_unit_test;
    import ffra_pkg::*;

    typedef struct packed {
        logic        op;
        logic [47:0] req_size;
        logic [63:0] req_addr;
    } alloc_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] grant_addr;
    } alloc_resp_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [111:0]  s_tdata = '0;
    logic          s_tuser = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [71:0]   m_tdata;
    logic          cfg_we = 1'b0;
    logic          cfg_index = 1'b0;
    logic [63:0]   cfg_wdata = '0;

    first_fit_range_allocator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // shadow allocator state
    logic [63:0] heap_lo, heap_hi;
    logic [63:0] tbl_base[MAX_RANGES];
    logic [63:0] tbl_len[MAX_RANGES];
    int          tbl_cnt;

    alloc_req_t  pending_reqs[$];
    alloc_resp_t expected_resps[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          quiet = 0;     // no idling stretch
    int          hold_off = 0;  // long receiver stall
    bit          done_flag = 0;

    function automatic logic [63:0] gap_of(logic [63:0] lo, logic [63:0] hi);
        return (hi > lo) ? hi - lo : 64'd0;
    endfunction

    function automatic logic [63:0] end_of(int i);
        return (tbl_len[i] > ~tbl_base[i]) ? '1 : tbl_base[i] + tbl_len[i];
    endfunction

    function automatic void place_range(int pos, logic [63:0] b, logic [63:0] l);
        for (int i = tbl_cnt; i > pos; i--) begin
            tbl_base[i] = tbl_base[i-1];
            tbl_len[i] = tbl_len[i-1];
        end
        tbl_base[pos] = b;
        tbl_len[pos] = l;
        tbl_cnt++;
    endfunction

    function automatic alloc_resp_t predict_alloc(alloc_req_t r);
        alloc_resp_t res;
        logic [63:0] sz, e;
        int pos;
        res = '0;
        if (r.op == OP_FREE) begin
            if (r.req_addr == 0) return res;
            for (int i = 0; i < tbl_cnt; i++) begin
                if (tbl_base[i] == r.req_addr) begin
                    for (int j = i; j + 1 < tbl_cnt; j++) begin
                        tbl_base[j] = tbl_base[j+1];
                        tbl_len[j] = tbl_len[j+1];
                    end
                    tbl_cnt--;
                    return res;
                end
            end
            res.status = STAT_NOTFOUND;
            return res;
        end
        sz = {16'd0, r.req_size};
        if (sz == 0) begin
            res.status = STAT_NOFIT;
            return res;
        end
        if (tbl_cnt >= MAX_RANGES) begin
            res.status = STAT_FULL;
            return res;
        end
        if (sz % PAGE_BYTES != 0) sz = sz + PAGE_BYTES - sz % PAGE_BYTES;
        pos = -1;
        if (tbl_cnt == 0) begin
            if (gap_of(heap_lo, heap_hi) >= sz) begin pos = 0; e = heap_lo; end
        end else if (gap_of(heap_lo, tbl_base[0]) >= sz) begin
            pos = 0; e = heap_lo;
        end else begin
            for (int i = 0; i + 1 < tbl_cnt && pos < 0; i++)
                if (gap_of(end_of(i), tbl_base[i+1]) >= sz) begin
                    pos = i + 1; e = end_of(i);
                end
            if (pos < 0 && gap_of(end_of(tbl_cnt-1), heap_hi) >= sz) begin
                e = end_of(tbl_cnt-1); pos = tbl_cnt;
            end
        end
        if (pos < 0) begin
            res.status = STAT_NOFIT;
            return res;
        end
        place_range(pos, e, sz);
        res.status = STAT_OK;
        res.grant_addr = e;
        return res;
    endfunction

    // driver
    always @(posedge aclk) begin
        alloc_req_t r;
        if (s_tvalid && s_tready) begin
            expected_resps.push_back(predict_alloc({s_tuser, s_tdata[47:0], s_tdata[111:48]}));
            void'(pending_reqs.pop_front());
        end
        if (aresetn && !(s_tvalid && !s_tready) && pending_reqs.size() > 0
            && (quiet || $urandom_range(99) >= 14)) begin
            r = pending_reqs[0];
            s_tvalid <= 1'b1;
            s_tuser <= r.op;
            s_tdata <= {r.req_addr, r.req_size};
        end else if (!(s_tvalid && !s_tready)) begin
            s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge aclk) begin
        alloc_resp_t got, exp_r;
        cycles++;
        if (m_tvalid && m_tready) begin
            got = {m_tdata[1:0], m_tdata[65:2]};
            if (expected_resps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word status=%0d grant=%h",
                                               got.status, got.grant_addr);
            end else begin
                exp_r = expected_resps.pop_front();
                if (got.status !== exp_r.status || got.grant_addr !== exp_r.grant_addr
                    || m_tdata[71:66] !== 6'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp status=%0d grant=%h, got status=%0d grant=%h",
                                 exp_r.status, exp_r.grant_addr, got.status, got.grant_addr);
                end
            end
        end
        if (hold_off > 0) begin
            hold_off--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && (quiet || $urandom_range(99) >= 14);
        end
        if (cycles > 3000000 && !done_flag) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic wait_drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_resps.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_HEAP_START) heap_lo = v; else heap_hi = v;
        @(posedge aclk);
    endtask

    task automatic push_req(logic op, logic [47:0] sz, logic [63:0] a);
        alloc_req_t r;
        r.op = op; r.req_size = sz; r.req_addr = a;
        pending_reqs.push_back(r);
    endtask

    // random phase: mostly allocs and frees of page-aligned heap addresses
    task automatic random_phase(int n, int size_cap);
        logic [63:0] a;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: push_req(OP_ALLOC, 48'($urandom_range(size_cap)), 64'($urandom));
                4, 5, 6: begin
                    a = heap_lo + 64'($urandom_range(63)) * PAGE_BYTES;
                    push_req(OP_FREE, 48'({$urandom, $urandom}), a);
                end
                7: push_req(OP_ALLOC, 48'({$urandom, $urandom}), {$urandom, $urandom});
                8: push_req(OP_FREE, 48'($urandom), {$urandom, $urandom});
                default: push_req(OP_FREE, 48'd0, 64'd0);
            endcase
        end
    endtask

    initial begin
        tbl_cnt = 0;
        heap_lo = 0;
        heap_hi = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty heap at reset bounds
        push_req(OP_ALLOC, 48'd1, 64'd0);
        push_req(OP_ALLOC, 48'd0, 64'd0);
        push_req(OP_FREE, 48'd0, 64'd0);
        push_req(OP_FREE, '1, '1);
        wait_drain();

        write_reg(CFG_HEAP_START, 64'h1000);
        write_reg(CFG_HEAP_END, 64'h1000 + 64'd100 * PAGE_BYTES);
        push_req(OP_ALLOC, 48'd1, 64'd0);
        push_req(OP_ALLOC, 48'd4096, 64'd0);
        push_req(OP_ALLOC, 48'd4097, 64'd0);
        push_req(OP_FREE, 48'd0, 64'h2000);
        push_req(OP_ALLOC, 48'd100, 64'd0);
        push_req(OP_ALLOC, '1, '1);
        push_req(OP_FREE, 48'd0, 64'h1000);
        push_req(OP_FREE, 48'd0, 64'h1234);
        for (int i = 0; i < 66; i++) push_req(OP_ALLOC, 48'd1, 64'd0);
        wait_drain();
        // free the next-to-last entry
        push_req(OP_FREE, 48'd0, 64'h1000 + 64'(MAX_RANGES - 1) * PAGE_BYTES);
        push_req(OP_FREE, 48'd0, 64'h1000);
        wait_drain();

        // inverted bounds and top-of-space wrap
        write_reg(CFG_HEAP_START, '1 - 64'hFFF);
        write_reg(CFG_HEAP_END, 64'h0);
        push_req(OP_ALLOC, 48'd1, 64'd0);
        wait_drain();
        write_reg(CFG_HEAP_END, '1);
        push_req(OP_ALLOC, 48'd1, 64'd0);
        push_req(OP_ALLOC, 48'd1, 64'd0);
        wait_drain();

        // main random phases; long receiver stall at the start of the first
        write_reg(CFG_HEAP_START, 64'h10_0000);
        write_reg(CFG_HEAP_END, 64'h10_0000 + 64'd80 * PAGE_BYTES);
        hold_off = 2000;
        random_phase(450, 3 * PAGE_BYTES);
        wait_drain();
        for (int i = 0; i < 70; i++) push_req(OP_FREE, 48'd0, 64'h10_0000 + 64'(i) * PAGE_BYTES);
        quiet = 1;
        random_phase(200, 2 * PAGE_BYTES);
        wait_drain();
        quiet = 0;
        write_reg(CFG_HEAP_START, 64'hFFFF_FFFF_FFF0_0000);
        write_reg(CFG_HEAP_END, '1);
        random_phase(550, 12 * PAGE_BYTES);
        wait_drain();

        done_flag = 1;
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
